// ----- rtl/core/integer_calculator_alu_assert.svh -----
// Assertion macros used by the checker file.
`ifndef INTEGER_CALCULATOR_ALU_ASSERT_SVH
`define INTEGER_CALCULATOR_ALU_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define ICA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on the next clock edge.
`define ICA_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/core/ica_pkg.sv -----
package ica_pkg;
	localparam int DataWidth = 32;
	localparam int FracBits  = 16;
	localparam int QuoBits   = DataWidth + FracBits;
	localparam int SqrtSteps = (DataWidth + 1) / 2 + FracBits;
	localparam int RootBits  = SqrtSteps;
	localparam int RemBits   = SqrtSteps + 2;
	localparam int CntBits   = $clog2(QuoBits + 1);

	typedef enum logic [2:0] {
		ACT_ADD  = 3'd0,
		ACT_REM  = 3'd1,
		ACT_DIV  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_FDIV = 3'd4,
		ACT_POW  = 3'd5,
		ACT_SQRT = 3'd6,
		ACT_NONE = 3'd7
	} action_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture operands, set up the chosen operation
		logic step;    // one iteration of the active operation
		logic finish;  // form the result fields
	} ica_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic done;    // iterations complete
	} ica_sts_t;
endpackage

// ----- rtl/core/ica_ctrl.sv -----
module ica_ctrl
	import ica_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ica_cmd_t cmd,
	input  ica_sts_t sts
);
	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN, ST_OUT} state_t;
	state_t state_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd.load   = in_valid && (state_q == ST_IDLE);
		cmd.step   = (state_q == ST_RUN) && !sts.done;
		cmd.finish = (state_q == ST_FIN);
	end

	// Sequencer: load, iterate, finish, hold result until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_RUN;
				ST_RUN:  if (sts.done) state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_OUT;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/ica_datapath.sv -----
module ica_datapath
	import ica_pkg::*;
(
	input  logic                        clk,
	input  ica_cmd_t                    cmd,
	output ica_sts_t                    sts,
	input  logic [2:0]                  action,
	input  logic signed [DataWidth-1:0] operand_a,
	input  logic signed [DataWidth-1:0] operand_b,
	output logic signed [DataWidth-1:0] int_result,
	output logic signed [DataWidth-1:0] fixed_result,
	output logic [DataWidth-1:0]        root_a,
	output logic [DataWidth-1:0]        root_b,
	output logic                        error
);
	localparam logic [DataWidth-1:0] MaxPos = {1'b0, {(DataWidth-1){1'b1}}};
	localparam logic [DataWidth-1:0] MinNeg = {1'b1, {(DataWidth-1){1'b0}}};

	action_t               act_q;
	logic [DataWidth-1:0]  a_q, b_q;
	logic                  neg_a_q, neg_b_q;
	logic [CntBits-1:0]    cnt_q;
	// divider
	logic [QuoBits-1:0]    dvd_q;
	logic [DataWidth:0]    drem_q;
	logic [QuoBits-1:0]    quo_q;
	logic [DataWidth-1:0]  mb_q;
	// power / multiply
	logic [DataWidth-1:0]  pbase_q, pexp_q, pacc_q;
	// two square root units
	logic [2*SqrtSteps-1:0] sa_q, sb_q;
	logic [RemBits-1:0]     ra_q, rb_q;
	logic [RootBits-1:0]    rta_q, rtb_q;

	logic [DataWidth-1:0]  mag_a, mag_b;
	logic [DataWidth:0]    dshift, dsub;
	logic                  dge;
	logic                  fdiv, div_zero;
	logic [DataWidth-1:0]  quo_lo, rem_lo, fq_mag, sq_err;
	logic                  fneg;
	logic [QuoBits-1:0]    flimit;
	logic [RemBits-1:0]    sa_rem, sb_rem, sa_trial, sb_trial;
	logic [CntBits-1:0]    steps_need;

	assign mag_a = operand_a[DataWidth-1] ? DataWidth'(-operand_a) : operand_a;
	assign mag_b = operand_b[DataWidth-1] ? DataWidth'(-operand_b) : operand_b;
	assign fdiv  = (act_q == ACT_FDIV);

	// Restoring divider step, one quotient bit a cycle
	assign dshift = {drem_q[DataWidth-1:0], dvd_q[QuoBits-1]};
	assign dge    = dshift >= {1'b0, mb_q};
	assign dsub   = dge ? dshift - {1'b0, mb_q} : dshift;

	// Square root steps, one root bit a cycle per operand
	assign sa_rem   = {ra_q[RemBits-3:0], sa_q[2*SqrtSteps-1 -: 2]};
	assign sb_rem   = {rb_q[RemBits-3:0], sb_q[2*SqrtSteps-1 -: 2]};
	assign sa_trial = {rta_q, 2'b01};
	assign sb_trial = {rtb_q, 2'b01};

	always_comb begin
		unique case (act_q)
			ACT_REM, ACT_DIV: steps_need = CntBits'(DataWidth);
			ACT_FDIV:         steps_need = CntBits'(QuoBits);
			ACT_POW:          steps_need = CntBits'(DataWidth);
			ACT_SQRT:         steps_need = CntBits'(SqrtSteps);
			default:          steps_need = CntBits'(1);
		endcase
	end
	assign sts.done = (cnt_q == steps_need);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action_t'(action);
			a_q     <= operand_a;
			b_q     <= operand_b;
			neg_a_q <= operand_a[DataWidth-1];
			neg_b_q <= operand_b[DataWidth-1];
			cnt_q   <= '0;
			mb_q    <= mag_b;
			drem_q  <= '0;
			quo_q   <= '0;
			dvd_q   <= (action == ACT_FDIV) ? {mag_a, {FracBits{1'b0}}}
			                                : QuoBits'(mag_a) << FracBits;
			pbase_q <= operand_a;
			pexp_q  <= operand_b;
			pacc_q  <= (action == ACT_MUL) ? operand_a * operand_b : DataWidth'(1);
			sa_q    <= {operand_a, {(2*SqrtSteps-DataWidth){1'b0}}};
			sb_q    <= {operand_b, {(2*SqrtSteps-DataWidth){1'b0}}};
			ra_q    <= '0;
			rb_q    <= '0;
			rta_q   <= '0;
			rtb_q   <= '0;
		end else if (cmd.step) begin
			cnt_q  <= cnt_q + 1'b1;
			dvd_q  <= dvd_q << 1;
			drem_q <= dsub;
			quo_q  <= {quo_q[QuoBits-2:0], dge};
			// power: one exponent bit a cycle, LSB first
			if (act_q == ACT_POW) begin
				if (pexp_q[0]) pacc_q <= pacc_q * pbase_q;
				pbase_q <= pbase_q * pbase_q;
				pexp_q  <= pexp_q >> 1;
			end
			sa_q <= sa_q << 2;
			sb_q <= sb_q << 2;
			if (sa_rem >= sa_trial) begin
				ra_q  <= sa_rem - sa_trial;
				rta_q <= {rta_q[RootBits-2:0], 1'b1};
			end else begin
				ra_q  <= sa_rem;
				rta_q <= {rta_q[RootBits-2:0], 1'b0};
			end
			if (sb_rem >= sb_trial) begin
				rb_q  <= sb_rem - sb_trial;
				rtb_q <= {rtb_q[RootBits-2:0], 1'b1};
			end else begin
				rb_q  <= sb_rem;
				rtb_q <= {rtb_q[RootBits-2:0], 1'b0};
			end
		end
	end

	// Result formation
	assign div_zero = (b_q == '0);
	assign quo_lo   = quo_q[DataWidth-1:0];
	assign rem_lo   = drem_q[DataWidth-1:0];
	assign fneg     = neg_a_q ^ neg_b_q;
	assign flimit   = fneg ? QuoBits'(MinNeg) : QuoBits'(MaxPos);
	assign fq_mag   = fneg ? DataWidth'(-quo_q[DataWidth-1:0]) : quo_q[DataWidth-1:0];
	assign sq_err   = '0;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			int_result   <= '0;
			fixed_result <= '0;
			root_a       <= sq_err;
			root_b       <= sq_err;
			error        <= 1'b0;
			unique case (act_q)
				ACT_ADD: int_result <= a_q + b_q;
				ACT_MUL: int_result <= pacc_q;
				ACT_POW: int_result <= b_q[DataWidth-1] ? DataWidth'(1) : pacc_q;
				ACT_REM: begin
					if (div_zero) error <= 1'b1;
					else int_result <= neg_a_q ? DataWidth'(-rem_lo) : rem_lo;
				end
				ACT_DIV: begin
					if (div_zero) error <= 1'b1;
					else int_result <= fneg ? DataWidth'(-quo_lo) : quo_lo;
				end
				ACT_FDIV: begin
					if (div_zero) error <= 1'b1;
					else if (quo_q > flimit) fixed_result <= fneg ? MinNeg : MaxPos;
					else fixed_result <= fq_mag;
				end
				ACT_SQRT: begin
					error  <= neg_a_q | neg_b_q;
					root_a <= neg_a_q ? '0 : DataWidth'(rta_q);
					root_b <= neg_b_q ? '0 : DataWidth'(rtb_q);
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/core/integer_calculator_alu.sv -----
// Integer calculator ALU. One item in, one result out, one item at a time.
// Add and multiply use none of the iterative units; remainder, divide and power
// go one bit a cycle over 32 operand bits in the shared divider or the
// square-and-multiply loop, fractional divide over 48 quotient bits, square
// root over 32 root bits, both roots in parallel units.
module integer_calculator_alu
	import ica_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  action,
	input  logic signed [DataWidth-1:0] operand_a,
	input  logic signed [DataWidth-1:0] operand_b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [DataWidth-1:0] int_result,
	output logic signed [DataWidth-1:0] fixed_result,
	output logic [DataWidth-1:0]        root_a,
	output logic [DataWidth-1:0]        root_b,
	output logic                        error
);
	ica_cmd_t cmd;
	ica_sts_t sts;

	ica_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
	);

	ica_datapath u_dp (
		.clk, .cmd, .sts, .action, .operand_a, .operand_b,
		.int_result, .fixed_result, .root_a, .root_b, .error
	);
endmodule

// ----- rtl/core/ica_checker.sv -----
`include "integer_calculator_alu_assert.svh"
module ica_checker
	import ica_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic error,
	input logic [DataWidth-1:0] root_a
);
	`ICA_ASSERT(a_no_overlap, !(in_ready && out_valid), "ready while result pending")
	`ICA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "took two items")
	`ICA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(root_a) && $stable(error), "result dropped")
	`ICA_ASSERT_NEXT(a_out_done, out_valid && out_ready, in_ready, "not idle after transfer")
endmodule

bind integer_calculator_alu ica_checker u_ica_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .error, .root_a
);
